// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define SPQ_NEVER(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
		else $error("forbidden condition seen");
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop)
`define SPQ_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, codes and types of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int PRI_W        = 16;
	localparam int ID_W         = 32;
	localparam int CNT_OUT_W    = 5;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} spq_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

endpackage

// File: rtl/core/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue requests and their results.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [PRI_W-1:0] in_priority;
	logic signed [ID_W-1:0]  in_id;

	modport source (output valid, req_type, in_priority, in_id, input ready);
	modport sink   (input valid, req_type, in_priority, in_id, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    pop_valid;
	logic signed [PRI_W-1:0] out_priority;
	logic signed [ID_W-1:0]  out_id;
	logic                    was_empty;
	logic                    push_dropped;
	logic [CNT_OUT_W-1:0]    entry_count;

	modport source (output valid, pop_valid, out_priority, out_id, was_empty,
		push_dropped, entry_count, input ready);
	modport sink   (input valid, pop_valid, out_priority, out_id, was_empty,
		push_dropped, entry_count, output ready);
endinterface

// File: rtl/core/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with per-slot compare and shift, fill counter and
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_datapath import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spq_cmd_t                cmd,
	input  logic                    req_type,
	input  logic signed [PRI_W-1:0] in_priority,
	input  logic signed [ID_W-1:0]  in_id,
	output logic                    pop_valid,
	output logic signed [PRI_W-1:0] out_priority,
	output logic signed [ID_W-1:0]  out_id,
	output logic                    was_empty,
	output logic                    push_dropped,
	output logic [CNT_OUT_W-1:0]    entry_count
);

	logic                    req_type_q;
	logic signed [PRI_W-1:0] req_pri_q;
	logic signed [ID_W-1:0]  req_id_q;

	logic signed [PRI_W-1:0] pri_q [CAPACITY];
	logic signed [ID_W-1:0]  id_q  [CAPACITY];
	logic signed [PRI_W-1:0] pri_nxt [CAPACITY];
	logic signed [ID_W-1:0]  id_nxt  [CAPACITY];
	logic [CAPACITY-1:0]     gt;
	logic [CAPACITY-1:0]     at_end;

	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           fill_nxt;
	logic [CW+CNT_OUT_W-1:0] fill_ext;
	logic                    full;
	logic                    empty;
	logic                    do_push;
	logic                    do_pop;

	logic                    pop_valid_q;
	logic signed [PRI_W-1:0] out_pri_q;
	logic signed [ID_W-1:0]  out_id_q;
	logic                    was_empty_q;
	logic                    dropped_q;
	logic [CNT_OUT_W-1:0]    count_q;

	assign full    = (fill_q == CW'(CAPACITY));
	assign empty   = (fill_q == '0);
	assign do_push = cmd.exec && (req_type_q == REQ_PUSH) && !full;
	assign do_pop  = cmd.exec && (req_type_q == REQ_POP) && !empty;

	always_comb begin
		fill_nxt = fill_q;
		if (do_push) begin
			fill_nxt = fill_q + CW'(1);
		end else if (do_pop) begin
			fill_nxt = fill_q - CW'(1);
		end
	end
	assign fill_ext = (CW + CNT_OUT_W)'(fill_nxt);

	// thermometer of stored slots that sort behind the new entry
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i]     = (CW'(i) < fill_q) && (pri_q[i] > req_pri_q);
			at_end[i] = (CW'(i) == fill_q);
		end
	end

	always_comb begin
		int ip;
		int in;
		for (int i = 0; i < CAPACITY; i++) begin
			ip = (i == 0) ? 0 : i - 1;
			in = (i == CAPACITY - 1) ? i : i + 1;
			pri_nxt[i] = pri_q[i];
			id_nxt[i]  = id_q[i];
			if (do_pop) begin
				pri_nxt[i] = pri_q[in];
				id_nxt[i]  = id_q[in];
			end else if (do_push) begin
				if ((i != 0) && gt[ip]) begin
					pri_nxt[i] = pri_q[ip];
					id_nxt[i]  = id_q[ip];
				end else if (gt[i] || at_end[i]) begin
					pri_nxt[i] = req_pri_q;
					id_nxt[i]  = req_id_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			pri_q[i] <= pri_nxt[i];
			id_q[i]  <= id_nxt[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			req_pri_q  <= in_priority;
			req_id_q   <= in_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pop_valid_q <= do_pop;
			out_pri_q   <= do_pop ? pri_q[0] : '0;
			out_id_q    <= do_pop ? id_q[0] : '0;
			was_empty_q <= (req_type_q == REQ_POP) && empty;
			dropped_q   <= (req_type_q == REQ_PUSH) && full;
			count_q     <= fill_ext[CNT_OUT_W-1:0];
		end
	end

	assign pop_valid    = pop_valid_q;
	assign out_priority = out_pri_q;
	assign out_id       = out_id_q;
	assign was_empty    = was_empty_q;
	assign push_dropped = dropped_q;
	assign entry_count  = count_q;

	`SPQ_NEVER(a_fill_bound, clk, arst_n, fill_q > CW'(CAPACITY))
	`SPQ_ASSERT(a_drop_full, clk, arst_n, (cmd.exec && req_type_q == REQ_PUSH && full) |=> (dropped_q && fill_q == CW'(CAPACITY)))
	`SPQ_ASSERT(a_pop_dec, clk, arst_n, (cmd.exec && req_type_q == REQ_POP && !empty) |=> (pop_valid_q && fill_q == $past(fill_q) - CW'(1)))

endmodule

// File: rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: accepts a request, runs the update, holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_cmd_t cmd
);

	spq_state_t state_q;
	spq_state_t state_nxt;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.load = in_ready;
				if (in_valid && in_ready) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`SPQ_ASSERT(a_exec_after_accept, clk, arst_n, (state_q == ST_EXEC) |-> $past(in_valid && in_ready))
	`SPQ_ASSERT(a_exec_slot_free, clk, arst_n, (state_q == ST_EXEC) |-> !out_valid_q)
	`SPQ_ASSERT(a_rsp_from_exec, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_EXEC))

endmodule

// File: rtl/core/stable_priority_queue.sv
// Latency: a request is accepted, updated the next cycle, its result valid the cycle after.
// Request flow: a new request is accepted only once the last update is done and the result
// slot is free or being read; all slots compare and shift in parallel at any fill level.
// Reset: arst_n clears the sequencer, result valid and the fill count; slot contents are
// not reset and are read only below the fill count.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, lowest priority first, equal priorities in arrival order.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req.req_type),
		.in_priority  (req.in_priority),
		.in_id        (req.in_id),
		.pop_valid    (rsp.pop_valid),
		.out_priority (rsp.out_priority),
		.out_id       (rsp.out_id),
		.was_empty    (rsp.was_empty),
		.push_dropped (rsp.push_dropped),
		.entry_count  (rsp.entry_count)
	);

endmodule
